[src/fpr_pkg.sv]
// Shared constants and types for the framed packet receiver.
`default_nettype none
package fpr_pkg;

   localparam int BYTE_W = 8;
   localparam int PHASE_W = 3;
   localparam int CSR_INDEX_W = 8;

   localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LEN  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_DATA = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CHK  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_END  = 3'd4;

   localparam logic [BYTE_W-1:0] REPLY_ACK  = 8'h06;
   localparam logic [BYTE_W-1:0] REPLY_NACK = 8'h15;

   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h02;
   localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h03;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_MARKER   = 8'd1;

   typedef struct packed {
      logic                hit;
      logic                verdict;
      logic [BYTE_W-1:0]   reply_byte;
   } fpr_result_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   start_marker;
      logic [BYTE_W-1:0]   end_marker;
   } fpr_markers_type;

endpackage
`default_nettype wire

[src/fpr_parser.sv]
// Frame walker: phase, length, payload count and running checksum per byte.
`default_nettype none
module fpr_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [fpr_pkg::BYTE_W-1:0]  rx_byte,
   input  wire fpr_pkg::fpr_markers_type    markers,
   output fpr_pkg::fpr_result_type          result
);
   import fpr_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  length_ff, length_in;
   logic [BYTE_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0]  check_ff, check_in;
   logic               match;

   assign match = (check_ff == sum_ff);

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      check_in  = check_ff;
      result.hit        = 1'b0;
      result.verdict    = ~match;
      result.reply_byte = match ? REPLY_ACK : REPLY_NACK;
      case (phase_ff)
         PH_LEN: begin
            length_in = rx_byte;
            sum_in    = rx_byte;
            count_in  = '0;
            phase_in  = (rx_byte == '0) ? PH_CHK : PH_DATA;
         end
         PH_DATA: begin
            sum_in   = sum_ff + rx_byte;
            count_in = count_ff + 8'd1;
            if (count_in >= length_ff) begin
               phase_in = PH_CHK;
            end
         end
         PH_CHK: begin
            check_in = rx_byte;
            phase_in = PH_END;
         end
         PH_END: begin
            result.hit = (rx_byte == markers.end_marker);
            phase_in   = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte == markers.start_marker) begin
               phase_in = PH_LEN;
               count_in = '0;
            end
         end
      endcase
      result.hit = result.hit & step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         length_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         check_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         check_ff  <= check_in;
      end
   end

endmodule
`default_nettype wire

[src/framed_packet_receiver_top.sv]
// Top level of the framed packet receiver with input and result registers.
//
// The receiver takes one byte per transaction and can accept a new byte in every
// cycle. A byte is registered on acceptance and walked through the frame state
// once the result register is free or being emptied; a closing end marker yields
// one result transaction, which is registered in the result register. While a
// result waits, the registered byte holds and the input stalls. The sustained
// rate of one byte per cycle is set by the phase and running-sum update, whose
// next values are computed combinationally from the registered byte.
// Marker registers are written through the csr port and take effect from the next
// byte processed; writes to indexes other than 0 and 1 are ignored.
`default_nettype none
module framed_packet_receiver_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [fpr_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_verdict,
   output logic [fpr_pkg::BYTE_W-1:0]            rsp_reply_byte,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [fpr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [fpr_pkg::BYTE_W-1:0]       csr_data
);
   import fpr_pkg::*;

   logic               in_valid_ff;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               step;
   fpr_markers_type    markers_ff;
   fpr_result_type     result;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_verdict_ff;
   logic [BYTE_W-1:0]  rsp_reply_ff;

   assign step      = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | step;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         markers_ff.start_marker <= START_MARKER_RESET;
         markers_ff.end_marker   <= END_MARKER_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_START_MARKER) begin
            markers_ff.start_marker <= csr_data;
         end
         if (csr_index == CSR_END_MARKER) begin
            markers_ff.end_marker <= csr_data;
         end
      end
   end

   fpr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .markers (markers_ff),
      .result  (result)
   );

   assign rsp_valid_in = result.hit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.hit) begin
         rsp_verdict_ff <= result.verdict;
         rsp_reply_ff   <= result.reply_byte;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_verdict    = rsp_verdict_ff;
   assign rsp_reply_byte = rsp_reply_ff;

`ifndef SYNTHESIS
   a_reply_matches_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reply_byte == (rsp_verdict ? REPLY_NACK : REPLY_ACK)))
      else $error("reply byte disagrees with verdict");

   a_result_from_step: assert property (@(posedge clock) disable iff (reset)
      result.hit |-> (in_valid_ff && (!rsp_valid_ff || rsp_ready)))
      else $error("result produced without a processed byte");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled while the pipeline could advance");
`endif

endmodule
`default_nettype wire
